// File: src/pscc_pkg.sv
// Shared types and constants of the point-set coplanarity check.
package pscc_pkg;

    // Width of one limb handled by the shared multiplier.
    localparam int LIMB_W = 32;
    // Limb index width; operands span at most four limbs.
    localparam int LIMB_IDX_W = 2;

    localparam int TOL_W = 15;
    localparam logic [TOL_W-1:0] TOL_RESET = 15'd41;

    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_COPLANAR  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OFF_PLANE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_FEW   = 2'd2;

    localparam int COUNT_W = 3;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CROSS_A1,
        ST_CROSS_A2,
        ST_CROSS_B1,
        ST_CROSS_B2,
        ST_CROSS_C1,
        ST_CROSS_C2,
        ST_OFF_A,
        ST_OFF_B,
        ST_OFF_C,
        ST_NORM_A,
        ST_NORM_B,
        ST_NORM_C,
        ST_RES_A,
        ST_RES_B,
        ST_RES_C,
        ST_SQUARE,
        ST_TOL_SQ,
        ST_THRESH,
        ST_FINISH
    } state_t;

    // One multiply-accumulate command for the shared unit.
    typedef struct packed {
        logic                  start;
        logic                  keep;
        logic                  neg;
        logic [LIMB_IDX_W-1:0] a_last;
        logic [LIMB_IDX_W-1:0] b_last;
    } mac_cmd_t;

endpackage

// File: src/pscc_if.sv
// Channel interfaces of the point-set coplanarity check.
interface pscc_point_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          last_point;

    modport source (
        output valid, point_x, point_y, point_z, last_point,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, last_point,
        output ready
    );
endinterface

interface pscc_status_if;
    logic                            valid;
    logic                            ready;
    logic [pscc_pkg::STATUS_W-1:0]   status;

    modport source (
        output valid, status,
        input  ready
    );
    modport sink (
        input  valid, status,
        output ready
    );
endinterface

interface pscc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pscc_pkg::TOL_W-1:0]    distance_tolerance;

    modport source (
        output valid, distance_tolerance,
        input  ready
    );
    modport sink (
        input  valid, distance_tolerance,
        output ready
    );
endinterface

// File: src/pscc_mac.sv
// Shared limb-serial multiply-accumulate unit of the coplanarity check.
module pscc_mac #(
    parameter int NUM_LIMBS = 3,
    parameter int ACC_WIDTH = 109
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  pscc_pkg::mac_cmd_t                          cmd,
    input  logic [NUM_LIMBS*pscc_pkg::LIMB_W-1:0]       a_mag,
    input  logic [NUM_LIMBS*pscc_pkg::LIMB_W-1:0]       b_mag,
    input  logic signed [ACC_WIDTH-1:0]                 init,
    output logic signed [ACC_WIDTH-1:0]                 acc,
    output logic                                        done
);

    localparam int LW  = pscc_pkg::LIMB_W;
    localparam int IW  = pscc_pkg::LIMB_IDX_W;
    localparam int SHW = IW + 1;

    logic [NUM_LIMBS*LW-1:0]       a_reg;
    logic [NUM_LIMBS*LW-1:0]       b_reg;
    logic [IW-1:0]                 a_last_reg;
    logic [IW-1:0]                 b_last_reg;
    logic                          neg_reg;
    logic [IW-1:0]                 i_reg;
    logic [IW-1:0]                 j_reg;
    logic                          run_reg;
    logic [2*LW-1:0]               prod_reg;
    logic [SHW-1:0]                shift_reg;
    logic                          prod_vld_reg;
    logic                          prod_last_reg;
    logic signed [ACC_WIDTH-1:0]   acc_reg;
    logic                          done_reg;

    logic [LW-1:0]                 a_limb;
    logic [LW-1:0]                 b_limb;
    logic                          last_pair;
    logic [ACC_WIDTH-1:0]          term;

    assign a_limb    = a_reg[i_reg*LW +: LW];
    assign b_limb    = b_reg[j_reg*LW +: LW];
    assign last_pair = (i_reg == a_last_reg) && (j_reg == b_last_reg);
    assign term      = ACC_WIDTH'(prod_reg) << (shift_reg * LW);

    // Sequencing of limb pairs; one partial product leaves per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
            done_reg      <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
        end
        else
        begin
            done_reg     <= prod_vld_reg && prod_last_reg;
            prod_vld_reg <= run_reg;
            if (cmd.start)
            begin
                run_reg <= 1'b1;
                i_reg   <= '0;
                j_reg   <= '0;
            end
            else if (run_reg)
            begin
                prod_last_reg <= last_pair;
                if (last_pair)
                begin
                    run_reg <= 1'b0;
                end
                if (j_reg == b_last_reg)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + 1'b1;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg      <= a_mag;
            b_reg      <= b_mag;
            a_last_reg <= cmd.a_last;
            b_last_reg <= cmd.b_last;
            neg_reg    <= cmd.neg;
            acc_reg    <= cmd.keep ? acc_reg : init;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= neg_reg ? (acc_reg - $signed(term)) : (acc_reg + $signed(term));
        end
        if (run_reg)
        begin
            prod_reg  <= a_limb * b_limb;
            shift_reg <= {1'b0, i_reg} + {1'b0, j_reg};
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// File: src/point_set_coplanarity_check.sv
// Top level of the point-set coplanarity check.
//
//   channel   direction   payload                                   transfer when
//   point     in          point_x, point_y, point_z, last_point     point.valid && point.ready
//   result    out         status                                    result.valid && result.ready
//   cfg       in          distance_tolerance                        cfg.valid && cfg.ready
//
// A point that only updates the set runs no multiply step. A point tested against the
// plane runs the residual and test steps; the third defining point, which builds the plane,
// runs the cross product, offset and norm steps (and the test steps when a leading origin
// is also tested). All are paced by the one shared 32x32 multiplier, limb by limb.
// Reset clears the set state, the result register and loads the tolerance with 41.
// A waiting result does not block the next point; only a last point stalls in its final
// cycle until the previous status has been transferred. The cfg channel is always ready.
module point_set_coplanarity_check #(
    parameter int COORD_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    pscc_point_if.sink        point,
    pscc_status_if.source     result,
    pscc_cfg_if.sink          cfg
);

    // Widths of the exact integer arithmetic, following the coordinate and tolerance widths.
    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;            // edge vector component
    localparam int PW   = 2 * W + 3;        // plane normal component
    localparam int OW   = 3 * W + 5;        // plane offset
    localparam int RW   = 3 * W + 6;        // residual
    localparam int NW   = 4 * W + 8;        // squared normal length
    localparam int T2W  = 2 * pscc_pkg::TOL_W;
    localparam int R2W  = 2 * RW;
    localparam int THW  = NW + T2W;
    localparam int ACCW = ((R2W > THW) ? R2W : THW) + 1;
    localparam int CMPW = ACCW - 1;
    localparam int LW   = pscc_pkg::LIMB_W;
    localparam int IW   = pscc_pkg::LIMB_IDX_W;
    localparam int NL   = (NW + LW - 1) / LW;
    localparam int OPW  = NL * LW + 1;
    localparam int CW   = pscc_pkg::COUNT_W;

    // Last limb index of each operand class.
    localparam logic [IW-1:0] LD_LAST = IW'((DW + LW - 1) / LW - 1);
    localparam logic [IW-1:0] LC_LAST = IW'((W + LW - 1) / LW - 1);
    localparam logic [IW-1:0] LP_LAST = IW'((PW + LW - 1) / LW - 1);
    localparam logic [IW-1:0] LR_LAST = IW'((RW + LW - 1) / LW - 1);
    localparam logic [IW-1:0] LN_LAST = IW'(NL - 1);
    localparam logic [IW-1:0] LT_LAST = IW'((T2W + LW - 1) / LW - 1);

    pscc_pkg::state_t state_reg, state_next;

    logic                              launched_reg, launched_next;
    logic [CW-1:0]                     cnt_reg, cnt_next;
    logic                              skipped_reg, skipped_next;
    logic                              off_seen_reg, off_seen_next;
    logic                              out_valid_reg, out_valid_next;
    logic [pscc_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [pscc_pkg::TOL_W-1:0]        tol_reg;

    // Current point and the three points that define the plane.
    logic signed [W-1:0]               px_reg, py_reg, pz_reg;
    logic                              last_reg;
    logic signed [W-1:0]               dpx_reg [3];
    logic signed [W-1:0]               dpy_reg [3];
    logic signed [W-1:0]               dpz_reg [3];

    // Plane and comparison operands.
    logic signed [PW-1:0]              pa_reg, pb_reg, pc_reg;
    logic signed [OW-1:0]              poff_reg;
    logic [NW-1:0]                     n2_reg;
    logic signed [RW-1:0]              res_reg;
    logic [R2W-1:0]                    r2_reg;
    logic [T2W-1:0]                    tol2_reg;

    logic                              accept;
    logic                              in_origin;
    logic [CW-1:0]                     pos;
    logic [CW-1:0]                     cnt_sat;
    logic signed [DW-1:0]              ux, uy, uz, vx, vy, vz;

    logic signed [OPW-1:0]             opa_s, opb_s, opa_abs, opb_abs;
    logic                              step_neg, step_keep, step_init_off;
    logic [IW-1:0]                     step_a_last, step_b_last;
    logic                              is_step;
    pscc_pkg::state_t                  step_follow;

    pscc_pkg::mac_cmd_t                mac_cmd;
    logic signed [ACCW-1:0]            mac_init;
    logic signed [ACCW-1:0]            mac_acc;
    logic                              mac_done;
    logic                              exceeds;

    assign accept    = point.valid && point.ready;
    assign in_origin = (cnt_reg == '0) && (point.point_x == '0) && (point.point_y == '0)
                       && (point.point_z == '0);
    assign pos       = cnt_reg - {{(CW-1){1'b0}}, skipped_reg};
    assign cnt_sat   = (cnt_reg == pscc_pkg::COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;

    // Edge vectors from the first defining point; the normal is their cross product.
    assign ux = DW'(dpx_reg[1]) - DW'(dpx_reg[0]);
    assign uy = DW'(dpy_reg[1]) - DW'(dpy_reg[0]);
    assign uz = DW'(dpz_reg[1]) - DW'(dpz_reg[0]);
    assign vx = DW'(dpx_reg[2]) - DW'(dpx_reg[0]);
    assign vy = DW'(dpy_reg[2]) - DW'(dpy_reg[0]);
    assign vz = DW'(dpz_reg[2]) - DW'(dpz_reg[0]);

    // The squared test: the point is off the plane when residual^2 exceeds tol^2 * |n|^2.
    assign exceeds = CMPW'(r2_reg) > mac_acc[CMPW-1:0];

    // Operand selection of each multiply step. A step either starts a fresh sum or adds
    // to the running one; the sign of the product is folded into add or subtract.
    always_comb
    begin
        opa_s         = '0;
        opb_s         = '0;
        step_neg      = 1'b0;
        step_keep     = 1'b1;
        step_init_off = 1'b0;
        step_a_last   = '0;
        step_b_last   = '0;
        is_step       = 1'b1;
        step_follow   = pscc_pkg::ST_FINISH;
        unique case (state_reg)
            pscc_pkg::ST_CROSS_A1:
            begin
                opa_s = OPW'(uy); opb_s = OPW'(vz); step_keep = 1'b0;
                step_a_last = LD_LAST; step_b_last = LD_LAST;
                step_follow = pscc_pkg::ST_CROSS_A2;
            end
            pscc_pkg::ST_CROSS_A2:
            begin
                opa_s = OPW'(uz); opb_s = OPW'(vy); step_neg = 1'b1;
                step_a_last = LD_LAST; step_b_last = LD_LAST;
                step_follow = pscc_pkg::ST_CROSS_B1;
            end
            pscc_pkg::ST_CROSS_B1:
            begin
                opa_s = OPW'(uz); opb_s = OPW'(vx); step_keep = 1'b0;
                step_a_last = LD_LAST; step_b_last = LD_LAST;
                step_follow = pscc_pkg::ST_CROSS_B2;
            end
            pscc_pkg::ST_CROSS_B2:
            begin
                opa_s = OPW'(ux); opb_s = OPW'(vz); step_neg = 1'b1;
                step_a_last = LD_LAST; step_b_last = LD_LAST;
                step_follow = pscc_pkg::ST_CROSS_C1;
            end
            pscc_pkg::ST_CROSS_C1:
            begin
                opa_s = OPW'(ux); opb_s = OPW'(vy); step_keep = 1'b0;
                step_a_last = LD_LAST; step_b_last = LD_LAST;
                step_follow = pscc_pkg::ST_CROSS_C2;
            end
            pscc_pkg::ST_CROSS_C2:
            begin
                opa_s = OPW'(uy); opb_s = OPW'(vx); step_neg = 1'b1;
                step_a_last = LD_LAST; step_b_last = LD_LAST;
                step_follow = pscc_pkg::ST_OFF_A;
            end
            pscc_pkg::ST_OFF_A:
            begin
                opa_s = OPW'(pa_reg); opb_s = OPW'(dpx_reg[0]);
                step_neg = 1'b1; step_keep = 1'b0;
                step_a_last = LP_LAST; step_b_last = LC_LAST;
                step_follow = pscc_pkg::ST_OFF_B;
            end
            pscc_pkg::ST_OFF_B:
            begin
                opa_s = OPW'(pb_reg); opb_s = OPW'(dpy_reg[0]); step_neg = 1'b1;
                step_a_last = LP_LAST; step_b_last = LC_LAST;
                step_follow = pscc_pkg::ST_OFF_C;
            end
            pscc_pkg::ST_OFF_C:
            begin
                opa_s = OPW'(pc_reg); opb_s = OPW'(dpz_reg[0]); step_neg = 1'b1;
                step_a_last = LP_LAST; step_b_last = LC_LAST;
                step_follow = pscc_pkg::ST_NORM_A;
            end
            pscc_pkg::ST_NORM_A:
            begin
                opa_s = OPW'(pa_reg); opb_s = OPW'(pa_reg); step_keep = 1'b0;
                step_a_last = LP_LAST; step_b_last = LP_LAST;
                step_follow = pscc_pkg::ST_NORM_B;
            end
            pscc_pkg::ST_NORM_B:
            begin
                opa_s = OPW'(pb_reg); opb_s = OPW'(pb_reg);
                step_a_last = LP_LAST; step_b_last = LP_LAST;
                step_follow = pscc_pkg::ST_NORM_C;
            end
            pscc_pkg::ST_NORM_C:
            begin
                opa_s = OPW'(pc_reg); opb_s = OPW'(pc_reg);
                step_a_last = LP_LAST; step_b_last = LP_LAST;
                // A skipped origin is tested at once: its residual is the offset.
                step_follow = skipped_reg ? pscc_pkg::ST_SQUARE : pscc_pkg::ST_FINISH;
            end
            pscc_pkg::ST_RES_A:
            begin
                opa_s = OPW'(pa_reg); opb_s = OPW'(px_reg);
                step_keep = 1'b0; step_init_off = 1'b1;
                step_a_last = LP_LAST; step_b_last = LC_LAST;
                step_follow = pscc_pkg::ST_RES_B;
            end
            pscc_pkg::ST_RES_B:
            begin
                opa_s = OPW'(pb_reg); opb_s = OPW'(py_reg);
                step_a_last = LP_LAST; step_b_last = LC_LAST;
                step_follow = pscc_pkg::ST_RES_C;
            end
            pscc_pkg::ST_RES_C:
            begin
                opa_s = OPW'(pc_reg); opb_s = OPW'(pz_reg);
                step_a_last = LP_LAST; step_b_last = LC_LAST;
                step_follow = pscc_pkg::ST_SQUARE;
            end
            pscc_pkg::ST_SQUARE:
            begin
                opa_s = OPW'(res_reg); opb_s = OPW'(res_reg); step_keep = 1'b0;
                step_a_last = LR_LAST; step_b_last = LR_LAST;
                step_follow = pscc_pkg::ST_TOL_SQ;
            end
            pscc_pkg::ST_TOL_SQ:
            begin
                opa_s = OPW'(tol_reg); opb_s = OPW'(tol_reg); step_keep = 1'b0;
                step_a_last = LT_LAST; step_b_last = LT_LAST;
                step_follow = pscc_pkg::ST_THRESH;
            end
            pscc_pkg::ST_THRESH:
            begin
                opa_s = OPW'(n2_reg); opb_s = OPW'(tol2_reg); step_keep = 1'b0;
                step_a_last = LN_LAST; step_b_last = LT_LAST;
                step_follow = pscc_pkg::ST_FINISH;
            end
            default:
            begin
                is_step = 1'b0;
            end
        endcase
    end

    assign opa_abs = opa_s[OPW-1] ? -opa_s : opa_s;
    assign opb_abs = opb_s[OPW-1] ? -opb_s : opb_s;

    assign mac_cmd.start  = is_step && !launched_reg;
    assign mac_cmd.keep   = step_keep;
    assign mac_cmd.neg    = step_neg ^ opa_s[OPW-1] ^ opb_s[OPW-1];
    assign mac_cmd.a_last = step_a_last;
    assign mac_cmd.b_last = step_b_last;
    assign mac_init       = step_init_off ? ACCW'(poff_reg) : '0;

    pscc_mac #(
        .NUM_LIMBS (NL),
        .ACC_WIDTH (ACCW)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .a_mag (opa_abs[NL*LW-1:0]),
        .b_mag (opb_abs[NL*LW-1:0]),
        .init  (mac_init),
        .acc   (mac_acc),
        .done  (mac_done)
    );

    // Sequencer: next state, set bookkeeping and the status register.
    always_comb
    begin
        state_next     = state_reg;
        launched_next  = launched_reg;
        cnt_next       = cnt_reg;
        skipped_next   = skipped_reg;
        off_seen_next  = off_seen_reg;
        out_valid_next = out_valid_reg && !result.ready;
        status_next    = status_reg;
        if (is_step)
        begin
            if (!launched_reg)
            begin
                launched_next = 1'b1;
            end
            else if (mac_done)
            begin
                launched_next = 1'b0;
                state_next    = step_follow;
                if (state_reg == pscc_pkg::ST_THRESH && exceeds)
                begin
                    off_seen_next = 1'b1;
                end
            end
        end
        else
        begin
            unique case (state_reg)
                pscc_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_origin)
                        begin
                            skipped_next = 1'b1;
                            state_next   = pscc_pkg::ST_FINISH;
                        end
                        else if (pos == CW'(2))
                        begin
                            state_next = pscc_pkg::ST_CROSS_A1;
                        end
                        else if (pos < CW'(2))
                        begin
                            state_next = pscc_pkg::ST_FINISH;
                        end
                        else
                        begin
                            state_next = pscc_pkg::ST_RES_A;
                        end
                    end
                end
                pscc_pkg::ST_FINISH:
                begin
                    if (!last_reg)
                    begin
                        cnt_next   = cnt_sat;
                        state_next = pscc_pkg::ST_IDLE;
                    end
                    else if (!out_valid_reg || result.ready)
                    begin
                        out_valid_next = 1'b1;
                        if (cnt_sat < CW'(2))
                        begin
                            status_next = pscc_pkg::STATUS_TOO_FEW;
                        end
                        else if (cnt_sat <= CW'(3) || !off_seen_reg)
                        begin
                            status_next = pscc_pkg::STATUS_COPLANAR;
                        end
                        else
                        begin
                            status_next = pscc_pkg::STATUS_OFF_PLANE;
                        end
                        cnt_next      = '0;
                        skipped_next  = 1'b0;
                        off_seen_next = 1'b0;
                        state_next    = pscc_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = pscc_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pscc_pkg::ST_IDLE;
            launched_reg  <= 1'b0;
            cnt_reg       <= '0;
            skipped_reg   <= 1'b0;
            off_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= pscc_pkg::STATUS_COPLANAR;
            tol_reg       <= pscc_pkg::TOL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            cnt_reg       <= cnt_next;
            skipped_reg   <= skipped_next;
            off_seen_reg  <= off_seen_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            if (cfg.valid)
            begin
                tol_reg <= cfg.distance_tolerance;
            end
        end
    end

    // Point, defining points and results of the multiply steps.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg   <= point.point_x;
            py_reg   <= point.point_y;
            pz_reg   <= point.point_z;
            last_reg <= point.last_point;
            if (!in_origin && pos < CW'(3))
            begin
                dpx_reg[pos[1:0]] <= point.point_x;
                dpy_reg[pos[1:0]] <= point.point_y;
                dpz_reg[pos[1:0]] <= point.point_z;
            end
        end
        if (launched_reg && mac_done)
        begin
            unique case (state_reg)
                pscc_pkg::ST_CROSS_A2: pa_reg   <= mac_acc[PW-1:0];
                pscc_pkg::ST_CROSS_B2: pb_reg   <= mac_acc[PW-1:0];
                pscc_pkg::ST_CROSS_C2: pc_reg   <= mac_acc[PW-1:0];
                pscc_pkg::ST_OFF_C:    poff_reg <= mac_acc[OW-1:0];
                pscc_pkg::ST_NORM_C:
                begin
                    n2_reg  <= mac_acc[NW-1:0];
                    res_reg <= RW'(poff_reg);
                end
                pscc_pkg::ST_RES_C:    res_reg  <= mac_acc[RW-1:0];
                pscc_pkg::ST_SQUARE:   r2_reg   <= mac_acc[R2W-1:0];
                pscc_pkg::ST_TOL_SQ:   tol2_reg <= mac_acc[T2W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign point.ready   = (state_reg == pscc_pkg::ST_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.status = status_reg;
    assign cfg.ready     = 1'b1;

endmodule

// File: bench/coplanarity_monitor.sv
// Checker that predicts and compares the status stream of the coplanarity check.
`timescale 1ns / 100ps

module coplanarity_monitor #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                point_valid,
    input  logic                                point_ready,
    input  logic signed [COORD_WIDTH-1:0]       point_x,
    input  logic signed [COORD_WIDTH-1:0]       point_y,
    input  logic signed [COORD_WIDTH-1:0]       point_z,
    input  logic                                point_last,
    input  logic                                result_valid,
    input  logic                                result_ready,
    input  logic [pscc_pkg::STATUS_W-1:0]       result_status,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [pscc_pkg::TOL_W-1:0]          cfg_tolerance,
    output int                                  mismatches,
    output int                                  outstanding
);

    // Local copy of the set state and of the tolerance register.
    logic [pscc_pkg::TOL_W-1:0]    tolerance;
    logic [pscc_pkg::COUNT_W-1:0]  set_count;
    logic                          origin_skipped;
    longint                        anchor_x [3];
    longint                        anchor_y [3];
    longint                        anchor_z [3];
    longint                        coef_a;
    longint                        coef_b;
    longint                        coef_c;
    longint                        coef_d;
    logic                          set_off_plane;
    logic [pscc_pkg::STATUS_W-1:0] status_expected [$];
    int                            fail_total = 0;

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [127:0] scaled_square(longint coef);
        logic [63:0] scaled;
        logic [127:0] wide;
        scaled = magnitude(coef) * tolerance;
        wide = {64'd0, scaled};
        return wide * wide;
    endfunction

    // Squared residual against squared tolerance times squared normal length;
    // both sides are exact, so no square root or division is needed.
    function automatic logic exceeds_tolerance(longint residual);
        logic [127:0] res_wide;
        logic [127:0] limit_sq;
        res_wide = {64'd0, magnitude(residual)};
        limit_sq = scaled_square(coef_a) + scaled_square(coef_b) + scaled_square(coef_c);
        return (res_wide * res_wide) > limit_sq;
    endfunction

    function automatic void clear_set();
        set_count = '0;
        origin_skipped = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            anchor_x[i] = 0;
            anchor_y[i] = 0;
            anchor_z[i] = 0;
        end
        coef_a = 0;
        coef_b = 0;
        coef_c = 0;
        coef_d = 0;
        set_off_plane = 1'b0;
    endfunction

    function automatic void fit_plane();
        longint ux, uy, uz, vx, vy, vz;
        ux = anchor_x[1] - anchor_x[0];
        uy = anchor_y[1] - anchor_y[0];
        uz = anchor_z[1] - anchor_z[0];
        vx = anchor_x[2] - anchor_x[0];
        vy = anchor_y[2] - anchor_y[0];
        vz = anchor_z[2] - anchor_z[0];
        coef_a = uy * vz - uz * vy;
        coef_b = uz * vx - ux * vz;
        coef_c = ux * vy - uy * vx;
        coef_d = -(coef_a * anchor_x[0] + coef_b * anchor_y[0] + coef_c * anchor_z[0]);
    endfunction

    function automatic void predict_point(longint x, longint y, longint z, logic last);
        int slot;
        logic [pscc_pkg::STATUS_W-1:0] verdict;
        if (set_count == 0 && x == 0 && y == 0 && z == 0)
        begin
            origin_skipped = 1'b1;
        end
        else
        begin
            slot = origin_skipped ? int'(set_count) - 1 : int'(set_count);
            if (slot < 3)
            begin
                anchor_x[slot] = x;
                anchor_y[slot] = y;
                anchor_z[slot] = z;
                if (slot == 2)
                begin
                    fit_plane();
                    // The skipped origin is tested too; its residual is the offset.
                    if (origin_skipped && exceeds_tolerance(coef_d))
                        set_off_plane = 1'b1;
                end
            end
            else if (exceeds_tolerance(coef_a * x + coef_b * y + coef_c * z + coef_d))
            begin
                set_off_plane = 1'b1;
            end
        end

        if (set_count < pscc_pkg::COUNT_MAX)
            set_count++;

        if (last)
        begin
            if (set_count < 2)
                verdict = pscc_pkg::STATUS_TOO_FEW;
            else if (set_count <= 3)
                verdict = pscc_pkg::STATUS_COPLANAR;
            else
                verdict = set_off_plane ? pscc_pkg::STATUS_OFF_PLANE
                                        : pscc_pkg::STATUS_COPLANAR;
            status_expected.push_back(verdict);
            clear_set();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [pscc_pkg::STATUS_W-1:0] want;
        if (!rst_n)
        begin
            tolerance = pscc_pkg::TOL_RESET;
            clear_set();
            status_expected.delete();
        end
        else
        begin
            // Results are checked before the point of this edge is predicted.
            if (result_valid && result_ready)
            begin
                if (status_expected.size() == 0)
                begin
                    $display("%0t: status transfer with nothing expected, actual %0d",
                             $time, result_status);
                    fail_total++;
                end
                else
                begin
                    want = status_expected.pop_front();
                    if (result_status !== want)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want, result_status);
                        fail_total++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                tolerance = cfg_tolerance;
            if (point_valid && point_ready)
                predict_point(point_x, point_y, point_z, point_last);
        end
        mismatches  <= fail_total;
        outstanding <= status_expected.size();
    end

endmodule

// File: bench/tb_top.sv
// Top of the coplanarity check testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int COORD_WIDTH = 16;
    // Allow for the slowest point, the longest sender gap and the longest
    // receiver stall, then a wide margin on top.
    localparam int IDLE_LIMIT = 3000;
    // Quiet cycles before a register write and before the verdict, so that a
    // point with no status of its own has surely finished.
    localparam int SETTLE_CYCLES = 200;
    localparam int PHASE_COUNT = 7;
    localparam int POINTS_PER_PHASE = 190;

    typedef struct {
        int x;
        int y;
        int z;
    } coord_t;

    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    pscc_point_if #(.COORD_WIDTH(COORD_WIDTH)) point_if ();
    pscc_status_if status_if ();
    pscc_cfg_if cfg_if ();

    point_set_coplanarity_check #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_if),
        .result (status_if),
        .cfg    (cfg_if)
    );

    int mismatches;
    int outstanding;

    coplanarity_monitor #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .point_valid   (point_if.valid),
        .point_ready   (point_if.ready),
        .point_x       (point_if.point_x),
        .point_y       (point_if.point_y),
        .point_z       (point_if.point_z),
        .point_last    (point_if.last_point),
        .result_valid  (status_if.valid),
        .result_ready  (status_if.ready),
        .result_status (status_if.status),
        .cfg_valid     (cfg_if.valid),
        .cfg_ready     (cfg_if.ready),
        .cfg_tolerance (cfg_if.distance_tolerance),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // When low, neither the point sender nor the status receiver idles.
    logic   gaps_on = 1'b1;
    int     points_sent = 0;
    int     idle_cycles = 0;
    coord_t point_batch [$];

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge clk)
    begin
        if ((point_if.valid && point_if.ready) || (status_if.valid && status_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Status receiver: ready drops for random stretches, mostly short ones.
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        status_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                status_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                status_if.ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 99) < 15)
                    stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                              : $urandom_range(15, 80);
            end
        end
    end

    function automatic int pick_signed(int bound);
        return int'($urandom_range(0, 2 * bound)) - bound;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic void add_point(int x, int y, int z);
        coord_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        point_batch.push_back(p);
    endfunction

    // Sender gap after a transfer. Valid is lowered only when a gap follows, so
    // that back-to-back points keep valid high without a second assignment.
    task automatic sender_pause();
        int r;
        int n;
        if (!gaps_on)
            return;
        r = $urandom_range(0, 99);
        if (r < 55)
            n = 0;
        else if (r < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(10, 60);
        if (n > 0)
        begin
            point_if.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_point(int x, int y, int z, logic last);
        point_if.valid      <= 1'b1;
        point_if.point_x    <= x[COORD_WIDTH-1:0];
        point_if.point_y    <= y[COORD_WIDTH-1:0];
        point_if.point_z    <= z[COORD_WIDTH-1:0];
        point_if.last_point <= last;
        do
            @(posedge clk);
        while (!point_if.ready);
        points_sent++;
        sender_pause();
    endtask

    // Sends the queued set; the final point carries the last mark.
    task automatic send_batch();
        foreach (point_batch[i])
            send_point(point_batch[i].x, point_batch[i].y, point_batch[i].z,
                       i == point_batch.size() - 1);
        point_batch.delete();
    endtask

    // Waits for every expected status, then lets the block settle. The first
    // edge makes sure the monitor has counted the most recent last point.
    task automatic drain();
        point_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [pscc_pkg::TOL_W-1:0] value);
        cfg_if.valid              <= 1'b1;
        cfg_if.distance_tolerance <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // A set whose points lie on the plane through base b spanned by u and v,
    // optionally led by the origin and with some points pushed off the plane.
    // A nonzero collinear_kind makes the defining points coincide or line up.
    function automatic void build_plane_set(int extras, logic lead_origin,
                                            logic through_origin, int collinear_kind,
                                            int noise_pct);
        int m;
        int bx, by, bz, ux, uy, uz, vx, vy, vz;
        int s, t, px, py, pz, amp;
        case ($urandom_range(0, 3))
            0: m = 8;
            1: m = 200;
            2: m = 2000;
            default: m = 4000;
        endcase
        ux = pick_signed(m);
        uy = pick_signed(m);
        uz = pick_signed(m);
        case (collinear_kind)
            1: begin vx = ux;  vy = uy;  vz = uz;  end
            2: begin vx = -ux; vy = -uy; vz = -uz; end
            3: begin vx = 0;   vy = 0;   vz = 0;   end
            default: begin vx = pick_signed(m); vy = pick_signed(m); vz = pick_signed(m); end
        endcase
        if (through_origin)
        begin
            s = pick_signed(1);
            t = pick_signed(1);
            bx = s * ux + t * vx;
            by = s * uy + t * vy;
            bz = s * uz + t * vz;
        end
        else
        begin
            bx = pick_signed(m);
            by = pick_signed(m);
            bz = pick_signed(m);
        end

        if (lead_origin)
            add_point(0, 0, 0);
        add_point(bx, by, bz);
        add_point(bx + ux, by + uy, bz + uz);
        add_point(bx + vx, by + vy, bz + vz);

        for (int i = 0; i < extras; i++)
        begin
            s = pick_signed(3);
            t = pick_signed(3);
            px = bx + s * ux + t * vx;
            py = by + s * uy + t * vy;
            pz = bz + s * uz + t * vz;
            if ($urandom_range(0, 99) < noise_pct)
            begin
                // Offsets from barely off to far off, around typical tolerances.
                case ($urandom_range(0, 2))
                    0: amp = $urandom_range(1, 3);
                    1: amp = $urandom_range(10, 100);
                    default: amp = $urandom_range(100, 700);
                endcase
                if ($urandom_range(0, 1))
                    amp = -amp;
                case ($urandom_range(0, 2))
                    0: px += amp;
                    1: py += amp;
                    default: pz += amp;
                endcase
            end
            add_point(px, py, pz);
        end
    endfunction

    // Unstructured set of any length, sometimes led by the origin.
    function automatic void build_scatter_set(int length);
        int i;
        i = 0;
        if ($urandom_range(0, 9) == 0)
        begin
            add_point(0, 0, 0);
            i = 1;
        end
        for (; i < length; i++)
        begin
            if ($urandom_range(0, 1))
                add_point(any_coord(), any_coord(), any_coord());
            else
                add_point(pick_signed(20), pick_signed(20), pick_signed(20));
        end
    endfunction

    initial
    begin : stimulus
        int phase_start;
        int r;
        int extras;
        logic lead;
        logic [pscc_pkg::TOL_W-1:0] tol;

        rst_n                     <= 1'b0;
        point_if.valid            <= 1'b0;
        point_if.point_x          <= '0;
        point_if.point_y          <= '0;
        point_if.point_z          <= '0;
        point_if.last_point       <= 1'b0;
        cfg_if.valid              <= 1'b0;
        cfg_if.distance_tolerance <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets, run at the reset tolerance.
        // A single point, and a single origin point, are too few.
        add_point(32767, -32768, 1);
        send_batch();
        add_point(0, 0, 0);
        send_batch();
        // Two points are coplanar whatever they are.
        add_point(-32768, -32768, -32768);
        add_point(32767, 32767, 32767);
        send_batch();
        // Three points only define the plane.
        add_point(5, -9, 300);
        add_point(-4000, 17, 2);
        add_point(123, 456, -789);
        send_batch();
        // Leading origin on the plane z = 0, with a tested point on it.
        add_point(0, 0, 0);
        add_point(4096, 0, 0);
        add_point(0, 4096, 0);
        add_point(4096, 4096, 0);
        send_batch();
        // Leading origin far from the plane of the next three points.
        add_point(0, 0, 0);
        add_point(1000, 0, 0);
        add_point(0, 1000, 0);
        add_point(0, 0, 1000);
        send_batch();
        // Collinear defining points give a zero normal, hence coplanar.
        add_point(1, 1, 1);
        add_point(2, 2, 2);
        add_point(3, 3, 3);
        add_point(500, -700, 9);
        send_batch();
        // Full-scale coordinates stress the widest products.
        add_point(32767, 32767, 32767);
        add_point(-32768, -32768, -32768);
        add_point(32767, -32768, 0);
        add_point(-32768, 32767, 32767);
        add_point(0, 0, -32768);
        send_batch();

        // Random phases, each at its own tolerance, extremes included.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain();
            case (phase)
                0: tol = '0;
                1: tol = 15'h7fff;
                2: tol = pscc_pkg::TOL_RESET;
                3: tol = 15'd1;
                4: tol = pscc_pkg::TOL_W'($urandom_range(2, 200));
                5: tol = pscc_pkg::TOL_W'($urandom_range(0, 32767));
                default: tol = pscc_pkg::TOL_W'($urandom_range(20, 120));
            endcase
            write_tolerance(tol);
            // One phase runs with neither side idling.
            gaps_on = (phase != 4);

            phase_start = points_sent;
            while (points_sent - phase_start < POINTS_PER_PHASE)
            begin
                r = $urandom_range(0, 99);
                if (r < 72)
                begin
                    extras = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 11)
                                                         : $urandom_range(1, 4);
                    lead = ($urandom_range(0, 3) == 0);
                    build_plane_set(extras, lead,
                                    $urandom_range(0, 99) < (lead ? 50 : 20),
                                    ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0,
                                    ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 100));
                end
                else if (r < 88)
                begin
                    build_scatter_set($urandom_range(4, 12));
                end
                else
                begin
                    build_scatter_set($urandom_range(1, 3));
                end
                send_batch();
            end
        end

        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
